// ----- design/gpm_pkg.sv -----
// Shared types and constants for the glob pattern matcher.
package gpm_pkg;

  localparam int MaxPositionsDef = 32;
  localparam int CfgW            = 6;
  localparam int SlotW           = 5;
  localparam int ByteW           = 8;
  localparam int ClassRows       = 256;
  localparam int InTdataW        = 16;
  localparam int OutTdataW       = 8;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeClass = 2'd1,
    ModeStart = 2'd2,
    ModeText  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindLit   = 2'd0,
    KindAny   = 2'd1,
    KindClass = 2'd2,
    KindStar  = 2'd3
  } kind_e;

  // Layout of the input tdata, lowest bits last.
  typedef struct packed {
    logic             member;
    logic [ByteW-1:0] byte_value;
    kind_e            kind;
    logic [SlotW-1:0] slot;
  } item_t;

endpackage

// ----- design/gpm_pos_table.sv -----
// Compiled pattern positions: kind and byte per position, one flop set each.
module gpm_pos_table import gpm_pkg::*; #(
  parameter int MaxPositions = MaxPositionsDef
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [SlotW-1:0] wr_slot_i,
  input  kind_e            wr_kind_i,
  input  logic [ByteW-1:0] wr_byte_i,
  output kind_e            kind_o [MaxPositions],
  output logic [ByteW-1:0] byte_o [MaxPositions]
);

  kind_e            kind_q [MaxPositions];
  logic [ByteW-1:0] byte_q [MaxPositions];

  for (genvar g = 0; g < MaxPositions; g++) begin : g_pos
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (32'(wr_slot_i) == g)) begin
        kind_q[g] <= wr_kind_i;
        byte_q[g] <= wr_byte_i;
      end
    end
    assign kind_o[g] = kind_q[g];
    assign byte_o[g] = byte_q[g];
  end

endmodule

// ----- design/gpm_class_mem.sv -----
// Class membership memory: one row per byte value, one bit per position.
module gpm_class_mem import gpm_pkg::*; #(
  parameter int MaxPositions = MaxPositionsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [ByteW-1:0]        wr_addr_i,
  input  logic [SlotW-1:0]        wr_slot_i,
  input  logic                    wr_member_i,
  input  logic                    rd_en_i,
  input  logic [ByteW-1:0]        rd_addr_i,
  output logic [MaxPositions-1:0] rd_row_o
);

  logic [MaxPositions-1:0] mem [ClassRows];
  logic [ClassRows-1:0]    row_vld_q;
  logic [MaxPositions-1:0] rd_data_q;
  logic                    rd_vld_q;
  logic [MaxPositions-1:0] wr_sel;

  always_comb begin
    for (int i = 0; i < MaxPositions; i++) begin
      wr_sel[i] = (32'(wr_slot_i) == i);
    end
  end

  // A row never written reads as zero; its first write fills the whole row.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int i = 0; i < MaxPositions; i++) begin
        if (!row_vld_q[wr_addr_i] || wr_sel[i]) begin
          mem[wr_addr_i][i] <= wr_sel[i] & wr_member_i;
        end
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- design/gpm_nfa_step.sv -----
// One NFA step: a start or text item advances the active set and closes over stars; other items keep it.
module gpm_nfa_step import gpm_pkg::*; #(
  parameter int MaxPositions = MaxPositionsDef,
  parameter int LenW         = $clog2(MaxPositions + 1)
) (
  input  mode_e                   mode_i,
  input  logic [ByteW-1:0]        byte_i,
  input  logic [MaxPositions:0]   active_i,
  input  kind_e                   kind_i [MaxPositions],
  input  logic [ByteW-1:0]        pos_byte_i [MaxPositions],
  input  logic [MaxPositions-1:0] class_row_i,
  input  logic [LenW-1:0]         used_len_i,
  output logic [MaxPositions:0]   next_o,
  output logic                    matched_o,
  output logic                    alive_o
);

  localparam int N      = MaxPositions + 1;
  localparam int Levels = $clog2(N);

  logic [N-1:0]            le_len;
  logic [MaxPositions-1:0] lt_len;
  logic [MaxPositions-1:0] hit;
  logic [MaxPositions-1:0] absorb;
  logic [N-1:0]            seed;
  logic [N-1:0]            prop;
  logic [N-1:0]            g_cur, p_cur, g_nxt, p_nxt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      le_len[i] = (i <= 32'(used_len_i));
    end
    for (int i = 0; i < MaxPositions; i++) begin
      lt_len[i] = (i < 32'(used_len_i));
      hit[i]    = 1'b0;
      absorb[i] = 1'b0;
      if (active_i[i] && lt_len[i]) begin
        case (kind_i[i])
          KindLit:   hit[i]    = (pos_byte_i[i] == byte_i);
          KindAny:   hit[i]    = 1'b1;
          KindClass: hit[i]    = class_row_i[i];
          KindStar:  absorb[i] = 1'b1;
          default:   hit[i]    = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    seed = '0;
    prop = '0;
    if (mode_i == ModeStart) begin
      seed[0] = 1'b1;
    end else begin
      seed[0] = absorb[0];
      for (int i = 1; i < N; i++) begin
        seed[i] = hit[i-1] | ((i < MaxPositions) ? absorb[i % MaxPositions] : 1'b0);
      end
    end
    // A star in use lets activity flow to the next position.
    for (int i = 1; i < N; i++) begin
      prop[i] = lt_len[i-1] && (kind_i[i-1] == KindStar);
    end
  end

  // Log-depth prefix scan over runs of stars.
  always_comb begin
    g_cur = seed;
    p_cur = prop;
    g_nxt = seed;
    p_nxt = prop;
    for (int l = 0; l < Levels; l++) begin
      g_nxt = g_cur;
      p_nxt = p_cur;
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          g_nxt[i] = g_cur[i] | (p_cur[i] & g_cur[i - (1 << l)]);
          p_nxt[i] = p_cur[i] & p_cur[i - (1 << l)];
        end
      end
      g_cur = g_nxt;
      p_cur = p_nxt;
    end
  end

  always_comb begin
    if (mode_i == ModeStart || mode_i == ModeText) begin
      next_o    = g_cur;
      matched_o = g_cur[used_len_i];
    end else begin
      next_o    = active_i;
      matched_o = 1'b0;
    end
    alive_o = |(next_o & le_len);
  end

endmodule

// ----- design/glob_pattern_matcher_unit.sv -----
// Top level of the glob pattern matcher: input register, NFA step, result register.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: slot, kind, byte_value, member
//                                               tuser: mode
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: matched, alive
//   cfg       in   cfg_valid_i/cfg_ready_o      pattern_length
//
// One item per cycle sustained while m_axis_tready stays high; a result passes the input
// register, then the result register. The class memory read is registered at input acceptance.
// Reset clears the active set, pattern length and class rows; positions stay unwritten.
// The input side keeps accepting while a result waits, until both stages are full.
module glob_pattern_matcher_unit import gpm_pkg::*; #(
  parameter int MaxPositions = MaxPositionsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // slot[4:0], kind[6:5], byte_value[14:7], member[15]
  input  logic [1:0]           s_axis_tuser,  // mode[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // matched[0], alive[1], zero fill
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgW-1:0]      cfg_data_i
);

  localparam int LenW = $clog2(MaxPositions + 1);

  item_t                   item;
  mode_e                   in_mode;
  logic                    s_fire;
  logic                    advance;
  logic                    slot_ok;

  logic                    in_vld_q, in_vld_d;
  mode_e                   in_mode_q;
  logic [ByteW-1:0]        in_byte_q;
  logic                    out_vld_q, out_vld_d;
  logic                    matched_q, alive_q;
  logic [MaxPositions:0]   active_q, active_d;
  logic [CfgW-1:0]         cfg_q;
  logic [LenW-1:0]         used_len;

  kind_e                   pos_kind [MaxPositions];
  logic [ByteW-1:0]        pos_byte [MaxPositions];
  logic [MaxPositions-1:0] class_row;
  logic                    matched_d, alive_d;

  assign item    = item_t'(s_axis_tdata);
  assign in_mode = mode_e'(s_axis_tuser);
  assign slot_ok = (32'(item.slot) < MaxPositions);

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_fire || (in_vld_q && !advance);
  assign out_vld_d     = advance ? in_vld_q : out_vld_q;

  assign cfg_ready_o = 1'b1;
  assign used_len    = (32'(cfg_q) > MaxPositions) ? LenW'(MaxPositions) : LenW'(cfg_q);

  gpm_pos_table #(
    .MaxPositions(MaxPositions)
  ) u_pos_table (
    .clk_i    (clk_i),
    .wr_en_i  (s_fire && in_mode == ModeLoad && slot_ok),
    .wr_slot_i(item.slot),
    .wr_kind_i(item.kind),
    .wr_byte_i(item.byte_value),
    .kind_o   (pos_kind),
    .byte_o   (pos_byte)
  );

  gpm_class_mem #(
    .MaxPositions(MaxPositions)
  ) u_class_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (s_fire && in_mode == ModeClass && slot_ok),
    .wr_addr_i  (item.byte_value),
    .wr_slot_i  (item.slot),
    .wr_member_i(item.member),
    .rd_en_i    (s_fire),
    .rd_addr_i  (item.byte_value),
    .rd_row_o   (class_row)
  );

  gpm_nfa_step #(
    .MaxPositions(MaxPositions),
    .LenW        (LenW)
  ) u_nfa_step (
    .mode_i     (in_mode_q),
    .byte_i     (in_byte_q),
    .active_i   (active_q),
    .kind_i     (pos_kind),
    .pos_byte_i (pos_byte),
    .class_row_i(class_row),
    .used_len_i (used_len),
    .next_o     (active_d),
    .matched_o  (matched_d),
    .alive_o    (alive_d)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mode_q <= in_mode;
      in_byte_q <= item.byte_value;
    end
    if (advance && in_vld_q) begin
      matched_q <= matched_d;
      alive_q   <= alive_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      active_q  <= '0;
      cfg_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance && in_vld_q) begin
        active_q <= active_d;
      end
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW - 2){1'b0}}, alive_q, matched_q};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the glob pattern matcher: directed cases, then random patterns.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gpm_pkg::*;

  localparam int StallPct      = 37;
  localparam int WatchdogLimit = 3000;
  localparam int MaxReports    = 10;
  localparam int PhaseItems    = 150;

  typedef struct packed {
    logic matched;
    logic alive;
  } verdict_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i    = '0;

  // Shadow of the matcher state
  kind_e                      pos_kind  [MaxPositionsDef];
  logic [ByteW-1:0]           pos_byte  [MaxPositionsDef];
  logic [MaxPositionsDef-1:0] class_map [ClassRows];
  logic [MaxPositionsDef:0]   live;
  logic [CfgW-1:0]            pat_len;

  verdict_t verdicts_q [$];
  logic     steady      = 1'b0;
  int       errors      = 0;
  int       n_items     = 0;
  int       n_results   = 0;
  int       idle_cycles = 0;

  glob_pattern_matcher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one item to the shadow state (load, class write or NFA step); returns the flags the block should report.
  function automatic verdict_t advance(mode_e mode, logic [SlotW-1:0] slot, kind_e kind,
                                       logic [ByteW-1:0] b, logic mem);
    verdict_t             v;
    logic [MaxPositionsDef:0] nxt;
    int                   len;
    int                   i;
    len = (pat_len > MaxPositionsDef) ? MaxPositionsDef : int'(pat_len);
    v.matched = 1'b0;
    case (mode)
      ModeLoad: begin
        pos_kind[slot] = kind;
        pos_byte[slot] = b;
      end
      ModeClass: begin
        class_map[b][slot] = mem;
      end
      default: begin
        nxt = '0;
        if (mode == ModeStart) begin
          nxt[0] = 1'b1;
        end else begin
          for (i = 0; i < len; i++) begin
            if (live[i]) begin
              case (pos_kind[i])
                KindLit:   if (pos_byte[i] == b) nxt[i+1] = 1'b1;
                KindAny:   nxt[i+1] = 1'b1;
                KindClass: if (class_map[b][i]) nxt[i+1] = 1'b1;
                default:   nxt[i] = 1'b1;  // star eats the byte and stays
              endcase
            end
          end
        end
        // stars may match an empty run
        for (i = 0; i < len; i++) begin
          if (nxt[i] && pos_kind[i] == KindStar) nxt[i+1] = 1'b1;
        end
        live = nxt;
        v.matched = live[len];
      end
    endcase
    v.alive = 1'b0;
    for (i = 0; i <= len; i++) begin
      if (live[i]) v.alive = 1'b1;
    end
    return v;
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(mode_e mode, logic [SlotW-1:0] slot, kind_e kind,
                           logic [ByteW-1:0] b, logic mem);
    item_t    it;
    verdict_t v;
    while (!steady && $urandom_range(99) < StallPct) @(negedge clk_i);
    it.slot       = slot;
    it.kind       = kind;
    it.byte_value = b;
    it.member     = mem;
    s_axis_tdata  = it;
    s_axis_tuser  = mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    v = advance(mode, slot, kind, b, mem);
    verdicts_q.insert(verdicts_q.size(), v);
    n_items++;
  endtask

  task automatic send_start();
    send_item(ModeStart, SlotW'($urandom_range(31)), kind_e'($urandom_range(3)),
              ByteW'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_byte(logic [ByteW-1:0] b);
    send_item(ModeText, SlotW'($urandom_range(31)), kind_e'($urandom_range(3)), b,
              1'($urandom_range(1)));
  endtask

  task automatic load_pos(logic [SlotW-1:0] slot, kind_e kind, logic [ByteW-1:0] b);
    send_item(ModeLoad, slot, kind, b, 1'($urandom_range(1)));
  endtask

  task automatic set_class(logic [SlotW-1:0] slot, logic [ByteW-1:0] b, logic mem);
    send_item(ModeClass, slot, kind_e'($urandom_range(3)), b, mem);
  endtask

  task automatic wait_drain();
    while (verdicts_q.size() != 0) @(negedge clk_i);
  endtask

  // Only written with nothing in flight, so the shadow update is exact.
  task automatic write_length(logic [CfgW-1:0] v);
    wait_drain();
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    pat_len = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly a small alphabet so texts and literals collide often.
  function automatic logic [ByteW-1:0] any_byte();
    if ($urandom_range(99) < 70) return ByteW'(8'h61 + $urandom_range(3));
    return ByteW'($urandom_range(255));
  endfunction

  function automatic logic [ByteW-1:0] class_byte(int pos);
    logic [ByteW-1:0] b;
    b = any_byte();
    repeat (16) begin
      if (class_map[b][pos]) return b;
      b = any_byte();
    end
    return b;
  endfunction

  task automatic test_before_start();
    send_byte(8'hFF);  // nothing active yet
    send_start();      // empty pattern: empty text matches
    send_byte(8'h00);
  endtask

  task automatic test_kinds();
    write_length(6'd4);
    load_pos(5'd0, KindLit, 8'h00);
    load_pos(5'd1, KindAny, 8'h5A);
    load_pos(5'd2, KindClass, 8'h33);
    load_pos(5'd3, KindStar, 8'hFF);
    set_class(5'd2, 8'hFF, 1'b1);
    set_class(5'd2, 8'h80, 1'b1);
    set_class(5'd2, 8'h80, 1'b0);
    send_start();
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_start();
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h80);  // removed from the class: text dies
  endtask

  // Shrink the pattern under a live text; its stale active bits must vanish.
  task automatic test_length_change();
    send_start();
    send_byte(8'h00);
    write_length(6'd1);
    load_pos(5'd31, KindLit, 8'hA5);
    send_byte(8'h7E);
  endtask

  task automatic build_pattern(int eff);
    kind_e k;
    int    i;
    int    r;
    for (i = 0; i < eff; i++) begin
      r = $urandom_range(99);
      k = (r < 40) ? KindLit : (r < 60) ? KindAny : (r < 80) ? KindClass : KindStar;
      load_pos(SlotW'(i), k, any_byte());
      if (k == KindClass) begin
        repeat ($urandom_range(5, 2)) set_class(SlotW'(i), any_byte(), $urandom_range(99) < 85);
      end
    end
  endtask

  // A text that follows the pattern, with occasional bad bytes, cut-offs and tails.
  task automatic send_text(int eff);
    logic [ByteW-1:0] b;
    int               i;
    int               n;
    send_start();
    for (i = 0; i < eff; i++) begin
      if ($urandom_range(99) < 5) return;
      n = (pos_kind[i] == KindStar) ? int'($urandom_range(3)) : 1;
      repeat (n) begin
        case (pos_kind[i])
          KindLit:   b = pos_byte[i];
          KindClass: b = class_byte(i);
          default:   b = any_byte();
        endcase
        if ($urandom_range(99) < 6) b = any_byte();
        send_byte(b);
      end
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(2, 1)) send_byte(any_byte());
  endtask

  task automatic test_random_patterns();
    int lens [9] = '{32, 63, 6, 1, 20, 0, 32, 3, 12};
    int p;
    int eff;
    int first;
    bit held;
    held = 1'b0;
    // every position gets written before any length can reach it
    for (p = 0; p < MaxPositionsDef; p++) begin
      load_pos(SlotW'(p), kind_e'($urandom_range(3)), any_byte());
    end
    for (p = 0; p < 9; p++) begin
      write_length(CfgW'(lens[p]));
      eff    = (lens[p] > MaxPositionsDef) ? MaxPositionsDef : lens[p];
      steady = (p == 2);
      first  = n_items;
      build_pattern(eff);
      while (n_items - first < PhaseItems) begin
        if (p == 0 && !held && n_items - first > PhaseItems / 2) begin
          wait_drain();
          held = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          send_text(eff);
        end else begin
          send_item(mode_e'($urandom_range(3)), SlotW'($urandom_range(31)),
                    kind_e'($urandom_range(3)), ByteW'($urandom_range(255)),
                    1'($urandom_range(1)));
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk_i) m_axis_tready = steady || ($urandom_range(99) >= StallPct);

  always @(posedge clk_i) begin : check_results
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.matched = m_axis_tdata[0];
      got.alive   = m_axis_tdata[1];
      if (verdicts_q.size() == 0) begin
        report_error($sformatf("unexpected result beat matched=%0b alive=%0b",
                               got.matched, got.alive));
      end else begin
        want = verdicts_q.pop_front();
        if (got.matched !== want.matched || got.alive !== want.alive) begin
          report_error($sformatf("result %0d: expected matched=%0b alive=%0b, got %0b %0b",
                                 n_results, want.matched, want.alive, got.matched, got.alive));
        end
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    live    = '0;
    pat_len = '0;
    foreach (class_map[b]) class_map[b] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_before_start();
    test_kinds();
    test_length_change();
    test_random_patterns();
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && verdicts_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gpm_pkg.sv
design/gpm_pos_table.sv
design/gpm_class_mem.sv
design/gpm_nfa_step.sv
design/glob_pattern_matcher_unit.sv
dv/testbench.sv
